// ----- design/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
// Needs clk and arst_n in scope where used; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/iirdf2_pkg.sv -----
// Shared types and constants of the biquad filter.
// No dependencies.
package iirdf2_pkg;

	localparam int COEF_BITS    = 18;
	localparam int COEF_FRAC    = 14;
	localparam int NUM_REGS     = 7;
	localparam int REG_IDX_BITS = 3;
	localparam int ADDR_BITS    = 5;
	localparam int DATA_BITS    = 32;
	localparam int TAP_IDX_BITS = 2;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic [REG_IDX_BITS-1:0]     reg_idx_t;
	typedef logic [TAP_IDX_BITS-1:0]     tap_idx_t;
	typedef logic [1:0]                  acc_op_t;
	typedef logic [1:0]                  opnd_sel_t;

	localparam reg_idx_t REG_GAIN  = 3'd0;
	localparam reg_idx_t REG_RECIP = 3'd1;
	localparam reg_idx_t REG_FB1   = 3'd2;
	localparam reg_idx_t REG_FB2   = 3'd3;
	localparam reg_idx_t REG_FF0   = 3'd4;
	localparam reg_idx_t REG_FF1   = 3'd5;
	localparam reg_idx_t REG_FF2   = 3'd6;

	localparam coef_t REG_RESET [NUM_REGS] = '{
		18'sd16384, 18'sd16384, 18'sd0, 18'sd0, 18'sd16384, 18'sd0, 18'sd0
	};

	localparam acc_op_t ACC_HOLD = 2'd0;
	localparam acc_op_t ACC_LOAD = 2'd1;
	localparam acc_op_t ACC_ADD  = 2'd2;
	localparam acc_op_t ACC_SUB  = 2'd3;

	localparam opnd_sel_t OPND_X   = 2'd0;
	localparam opnd_sel_t OPND_TAP = 2'd1;
	localparam opnd_sel_t OPND_V   = 2'd2;

	typedef struct packed {
		logic      x_en;
		logic      mul_en;
		reg_idx_t  coef_sel;
		opnd_sel_t opnd_sel;
		tap_idx_t  tap;
		acc_op_t   acc_op;
		logic      v_en;
		logic      store_en;
		logic      out_en;
	} dp_cmd_t;

endpackage

// ----- design/iirdf2_if.sv -----
// Stream channels of the biquad filter: input samples and filtered results.
// Standalone; width set by the instantiating level.
interface iirdf2_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface iirdf2_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ----- design/iirdf2_regs.sv -----
// APB coefficient register file of the biquad filter.
// Uses iirdf2_pkg for register indexes and reset values.
module iirdf2_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [iirdf2_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [iirdf2_pkg::DATA_BITS-1:0]     pwdata,
	output logic [iirdf2_pkg::DATA_BITS-1:0]     prdata,
	output logic                                 pready,
	output iirdf2_pkg::coef_t                    coefs [iirdf2_pkg::NUM_REGS]
);
	import iirdf2_pkg::*;

	reg_idx_t reg_idx;
	logic     idx_ok;
	coef_t    coef_q [NUM_REGS];

	assign reg_idx = paddr[ADDR_BITS-1:2];
	assign idx_ok  = (reg_idx < REG_IDX_BITS'(NUM_REGS));
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= REG_RESET[i];
			end
		end else if (psel && penable && pwrite && idx_ok) begin
			coef_q[reg_idx] <= coef_t'(pwdata[COEF_BITS-1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = DATA_BITS'(unsigned'(coef_q[reg_idx]));
		end
	end

	assign coefs = coef_q;

endmodule

// ----- design/iirdf2_dp.sv -----
// Datapath of the biquad filter: shared multiplier, accumulator, delay line,
// rounding, saturation and output word. Uses iirdf2_pkg for the command type.
module iirdf2_dp #(
	parameter int TAPS        = 3,
	parameter int SAMPLE_BITS = 16,
	parameter int STATE_BITS  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iirdf2_pkg::dp_cmd_t           cmd,
	input  iirdf2_pkg::coef_t             coefs [iirdf2_pkg::NUM_REGS],
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          clipped
);
	import iirdf2_pkg::*;

	localparam int SLOT_W = $clog2(TAPS);
	localparam int MAX_W  = (SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS;
	localparam int DW     = MAX_W + 5;
	localparam int PROD_W = COEF_BITS + DW;
	localparam int ACC_W  = PROD_W + 1;
	localparam int RND_W  = ACC_W - COEF_FRAC;
	localparam int HALF   = 1 << (COEF_FRAC - 1);

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [STATE_BITS-1:0]  delay_q [TAPS];
	logic [SLOT_W-1:0]             slot_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [DW-1:0]          v_q;
	logic                          clip_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clipped_q;

	logic [SLOT_W:0]               idx_sum;
	logic [SLOT_W-1:0]             rd_idx;
	coef_t                         coef;
	logic signed [DW-1:0]          opnd;
	logic signed [PROD_W-1:0]      prod_d;
	logic signed [ACC_W-1:0]       prod_ext;
	logic signed [ACC_W-1:0]       acc_half;
	logic signed [ACC_W-1:0]       prod_half;
	logic signed [RND_W-1:0]       acc_rnd;
	logic signed [RND_W-1:0]       prod_rnd;
	logic                          u_fits;
	logic                          y_fits;
	logic signed [STATE_BITS-1:0]  u_sat;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	assign idx_sum = {1'b0, slot_q} + (SLOT_W + 1)'(cmd.tap[SLOT_W-1:0]);
	assign rd_idx  = (idx_sum >= (SLOT_W + 1)'(TAPS)) ?
		SLOT_W'(idx_sum - (SLOT_W + 1)'(TAPS)) : SLOT_W'(idx_sum);

	assign coef = coefs[cmd.coef_sel];

	always_comb begin
		case (cmd.opnd_sel)
			OPND_X:   opnd = DW'(x_q);
			OPND_TAP: opnd = DW'(delay_q[rd_idx]);
			OPND_V:   opnd = v_q;
			default:  opnd = '0;
		endcase
	end

	assign prod_d    = coef * opnd;
	assign prod_ext  = ACC_W'(prod_q);
	assign acc_half  = acc_q + ACC_W'(HALF);
	assign prod_half = prod_ext + ACC_W'(HALF);
	assign acc_rnd   = RND_W'(acc_half >>> COEF_FRAC);
	assign prod_rnd  = RND_W'(prod_half >>> COEF_FRAC);

	assign u_fits = (&prod_rnd[RND_W-1:STATE_BITS-1]) | ~(|prod_rnd[RND_W-1:STATE_BITS-1]);
	assign y_fits = (&acc_rnd[RND_W-1:SAMPLE_BITS-1]) | ~(|acc_rnd[RND_W-1:SAMPLE_BITS-1]);
	assign u_sat  = u_fits ? STATE_BITS'(prod_rnd) :
		{prod_rnd[RND_W-1], {(STATE_BITS-1){~prod_rnd[RND_W-1]}}};
	assign y_sat  = y_fits ? SAMPLE_BITS'(acc_rnd) :
		{acc_rnd[RND_W-1], {(SAMPLE_BITS-1){~acc_rnd[RND_W-1]}}};

	always_ff @(posedge clk) begin
		if (cmd.x_en) begin
			x_q <= sample_in;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.v_en) begin
			v_q <= DW'(acc_rnd);
		end
		if (cmd.store_en) begin
			clip_q <= ~u_fits;
		end
		if (cmd.out_en) begin
			sample_out_q <= y_sat;
			clipped_q    <= clip_q | ~y_fits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				delay_q[i] <= '0;
			end
			slot_q <= '0;
		end else begin
			if (cmd.store_en) begin
				delay_q[slot_q] <= u_sat;
			end
			if (cmd.out_en) begin
				slot_q <= (slot_q == '0) ? SLOT_W'(TAPS - 1) : slot_q - 1'b1;
			end
		end
	end

	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

// ----- design/iirdf2_ctrl.sv -----
// Sequencer of the biquad filter: steps the shared multiplier through the
// feedback, scaling and feed-forward products. Uses iirdf2_pkg, assert_macros.svh.
`include "assert_macros.svh"
module iirdf2_ctrl #(
	parameter int TAPS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output iirdf2_pkg::dp_cmd_t cmd
);
	import iirdf2_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_FB      = 4'd1;
	localparam logic [3:0] ST_FB_LAST = 4'd2;
	localparam logic [3:0] ST_ROUND   = 4'd3;
	localparam logic [3:0] ST_SCALE   = 4'd4;
	localparam logic [3:0] ST_STORE   = 4'd5;
	localparam logic [3:0] ST_FF      = 4'd6;
	localparam logic [3:0] ST_FF_LAST = 4'd7;
	localparam logic [3:0] ST_OUT     = 4'd8;

	localparam tap_idx_t LAST_TAP = TAP_IDX_BITS'(TAPS - 1);
	localparam tap_idx_t TAP_ONE  = TAP_IDX_BITS'(1);

	logic [3:0] state_q;
	logic [3:0] state_d;
	tap_idx_t   tap_q;
	tap_idx_t   tap_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		tap_d        = tap_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.tap      = tap_q;
		cmd.acc_op   = ACC_HOLD;
		cmd.opnd_sel = OPND_TAP;
		cmd.coef_sel = REG_GAIN;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.x_en = 1'b1;
					tap_d    = '0;
					state_d  = ST_FB;
				end
			end
			ST_FB: begin
				cmd.mul_en = 1'b1;
				if (tap_q == '0) begin
					cmd.coef_sel = REG_GAIN;
					cmd.opnd_sel = OPND_X;
				end else begin
					cmd.coef_sel = REG_FB1 + REG_IDX_BITS'(tap_q) - REG_IDX_BITS'(1);
				end
				if (tap_q == TAP_ONE) begin
					cmd.acc_op = ACC_LOAD;
				end else if (tap_q != '0) begin
					cmd.acc_op = ACC_SUB;
				end
				tap_d = tap_q + 1'b1;
				if (tap_q == LAST_TAP) begin
					state_d = ST_FB_LAST;
				end
			end
			ST_FB_LAST: begin
				cmd.acc_op = ACC_SUB;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.v_en = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.mul_en   = 1'b1;
				cmd.coef_sel = REG_RECIP;
				cmd.opnd_sel = OPND_V;
				state_d      = ST_STORE;
			end
			ST_STORE: begin
				cmd.store_en = 1'b1;
				tap_d        = '0;
				state_d      = ST_FF;
			end
			ST_FF: begin
				cmd.mul_en   = 1'b1;
				cmd.coef_sel = REG_FF0 + REG_IDX_BITS'(tap_q);
				if (tap_q == TAP_ONE) begin
					cmd.acc_op = ACC_LOAD;
				end else if (tap_q != '0) begin
					cmd.acc_op = ACC_ADD;
				end
				tap_d = tap_q + 1'b1;
				if (tap_q == LAST_TAP) begin
					state_d = ST_FF_LAST;
				end
			end
			ST_FF_LAST: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_en = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			if (cmd.out_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_take_one_word, in_valid && in_ready, !in_ready)
	`ASSERT_IMPLIES(a_no_overwrite, cmd.out_en, !out_valid_q || out_ready)
	`ASSERT_IMPLIES(a_tap_bound, state_q == ST_FB || state_q == ST_FF, tap_q <= LAST_TAP)
	`ASSERT_IMPLIES(a_word_source, $rose(out_valid_q), $past(state_q) == ST_OUT)

endmodule

// ----- design/iir_direct_form_two_filter.sv -----
// Biquad IIR filter, direct form II; one shared multiplier-accumulator, 18-bit coefficients.
// The result word is registered after the feedback, scale, store and feed-forward steps.
// A new word is taken only after the last result is registered (one shared multiplier).
// A waiting result stalls the sequencer only at its final step.
// Reset (arst_n low, asynchronous) clears the delay line and loads the default coefficients.
module iir_direct_form_two_filter #(
	parameter int TAPS        = 3,
	parameter int SAMPLE_BITS = 16,
	parameter int STATE_BITS  = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	iirdf2_in_if.sink                        in_chan,
	iirdf2_out_if.source                     out_chan,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [iirdf2_pkg::ADDR_BITS-1:0] paddr,
	input  logic [iirdf2_pkg::DATA_BITS-1:0] pwdata,
	output logic [iirdf2_pkg::DATA_BITS-1:0] prdata,
	output logic                             pready
);
	import iirdf2_pkg::*;

	coef_t                         coefs [NUM_REGS];
	dp_cmd_t                       cmd;
	logic                          in_ready;
	logic                          out_valid;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	iirdf2_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	iirdf2_ctrl #(
		.TAPS (TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_chan.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_chan.ready),
		.cmd       (cmd)
	);

	iirdf2_dp #(
		.TAPS        (TAPS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.STATE_BITS  (STATE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.coefs      (coefs),
		.sample_in  (in_chan.sample_in),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	assign in_chan.ready       = in_ready;
	assign out_chan.valid      = out_valid;
	assign out_chan.sample_out = sample_out;
	assign out_chan.clipped    = clipped;

endmodule
